/* hw/rtl/pmf_pkg.sv */
`default_nettype none
package pmf_pkg;

  // Default window depth (largest pattern the block can mask)
  localparam int MAX_PATTERN_DEF = 16;

  // Field and register widths
  localparam int BYTE_W     = 8;
  localparam int LEN_W      = 5;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 2;

  // Masking character
  localparam logic [BYTE_W-1:0] STAR_BYTE = 8'h2A;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LEN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_HIGH = 2'd2;

endpackage
`default_nettype wire

/* hw/rtl/pmf_in_if.sv */
`default_nettype none
interface pmf_in_if;
  logic                      valid;
  logic                      ready;
  logic [pmf_pkg::BYTE_W-1:0] in_byte;
  logic                      in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface
`default_nettype wire

/* hw/rtl/pmf_out_if.sv */
`default_nettype none
interface pmf_out_if;
  logic                      valid;
  logic                      ready;
  logic [pmf_pkg::BYTE_W-1:0] out_byte;
  logic                      out_last;

  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface
`default_nettype wire

/* hw/rtl/pmf_front.sv */
`default_nettype none
module pmf_front #(
  parameter int MAX_PATTERN = pmf_pkg::MAX_PATTERN_DEF,
  localparam int CNT_W = $clog2(MAX_PATTERN + 1),
  localparam int CMD_W = 2 + CNT_W + MAX_PATTERN * pmf_pkg::BYTE_W
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [pmf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [pmf_pkg::CFG_DATA_W-1:0]   cfg_data,
  pmf_in_if.sink                                text_in,
  output logic                                  cmd_valid,
  input  wire logic                             cmd_ready,
  output logic [CMD_W-1:0]                      cmd
);

  // Configuration registers
  logic [pmf_pkg::LEN_W-1:0]      pattern_len;
  logic [pmf_pkg::CFG_DATA_W-1:0] pattern_low;
  logic [pmf_pkg::CFG_DATA_W-1:0] pattern_high;
  logic [2*pmf_pkg::CFG_DATA_W-1:0] pat_all;

  // Window of held bytes, oldest in slot 0
  logic [pmf_pkg::BYTE_W-1:0] win     [MAX_PATTERN];
  logic [pmf_pkg::BYTE_W-1:0] win_new [MAX_PATTERN];
  logic [pmf_pkg::BYTE_W-1:0] win_sh  [MAX_PATTERN];
  logic [CNT_W-1:0]           held;
  logic [CNT_W-1:0]           held_next;

  logic [CNT_W-1:0] len_eff;
  logic             len_zero;
  logic [CNT_W-1:0] hp;
  logic [CNT_W-1:0] hp1;
  logic             full;
  logic             match;
  logic             star;
  logic             accept;
  logic [CNT_W-1:0] cmd_cnt;

  assign pat_all  = {pattern_high, pattern_low};
  assign len_eff  = (pattern_len > pmf_pkg::LEN_W'(MAX_PATTERN)) ? CNT_W'(MAX_PATTERN)
                                                                : pattern_len[CNT_W-1:0];
  assign len_zero = (len_eff == '0);
  assign hp       = (held < len_eff) ? held : '0;
  assign hp1      = hp + CNT_W'(1);
  assign full     = !len_zero && (hp1 == len_eff);
  assign star     = full && match;

  assign text_in.ready = cmd_ready;
  assign accept        = text_in.valid && cmd_ready;

  // Insert new byte, parallel compare, one-byte shift
  always_comb begin
    for (int k = 0; k < MAX_PATTERN; k++) begin
      win_new[k] = (hp == CNT_W'(k)) ? text_in.in_byte : win[k];
    end
    match = 1'b1;
    for (int k = 0; k < MAX_PATTERN; k++) begin
      if ((CNT_W'(k) < len_eff) && (win_new[k] != pat_all[k*pmf_pkg::BYTE_W +: pmf_pkg::BYTE_W]))
        match = 1'b0;
    end
    for (int k = 0; k < MAX_PATTERN; k++) begin
      win_sh[k] = (k < MAX_PATTERN - 1) ? win_new[(k + 1) % MAX_PATTERN] : win_new[k];
    end
  end

  // Classify the word into a command for the back end
  always_comb begin
    if (len_zero)
      cmd_cnt = CNT_W'(1);
    else if (text_in.in_last || star)
      cmd_cnt = hp1;
    else
      cmd_cnt = CNT_W'(1);
    cmd_valid = accept && (len_zero || full || text_in.in_last);
    cmd = '0;
    for (int k = 0; k < MAX_PATTERN; k++) begin
      cmd[k*pmf_pkg::BYTE_W +: pmf_pkg::BYTE_W] = win_new[k];
    end
    cmd[MAX_PATTERN*pmf_pkg::BYTE_W +: CNT_W] = cmd_cnt;
    cmd[CMD_W-2] = star;
    cmd[CMD_W-1] = text_in.in_last;
  end

  // Held count update
  always_comb begin
    held_next = held;
    if (cfg_we && cfg_index == pmf_pkg::CFG_PATTERN_LEN)
      held_next = '0;
    else if (accept) begin
      if (len_zero || text_in.in_last || star)
        held_next = '0;
      else if (full)
        held_next = hp;
      else
        held_next = hp1;
    end
  end

  // Config and count registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_len  <= pmf_pkg::LEN_W'(1);
      pattern_low  <= '0;
      pattern_high <= '0;
      held         <= '0;
    end else begin
      held <= held_next;
      if (cfg_we) begin
        case (cfg_index)
          pmf_pkg::CFG_PATTERN_LEN:  pattern_len  <= cfg_data[pmf_pkg::LEN_W-1:0];
          pmf_pkg::CFG_PATTERN_LOW:  pattern_low  <= cfg_data;
          pmf_pkg::CFG_PATTERN_HIGH: pattern_high <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // Window storage (payload, no reset)
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int k = 0; k < MAX_PATTERN; k++) begin
        win[k] <= full ? win_sh[k] : win_new[k];
      end
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/pmf_queue.sv */
`default_nettype none
module pmf_queue #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr_valid,
  output logic                  wr_ready,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  rd_valid,
  input  wire logic             rd_ready,
  output logic [WIDTH-1:0]      rd_data
);

  // Two-entry queue between front and back
  logic [WIDTH-1:0] slot [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             push;
  logic             pop;

  assign wr_ready = (count != 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_data  = slot[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= wr_data;
  end

endmodule
`default_nettype wire

/* hw/rtl/pmf_back.sv */
`default_nettype none
module pmf_back #(
  parameter int MAX_PATTERN = pmf_pkg::MAX_PATTERN_DEF,
  localparam int CNT_W = $clog2(MAX_PATTERN + 1),
  localparam int CMD_W = 2 + CNT_W + MAX_PATTERN * pmf_pkg::BYTE_W
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cmd_valid,
  output logic                  cmd_ready,
  input  wire logic [CMD_W-1:0] cmd,
  pmf_out_if.source             text_out
);

  localparam int BYTES_W = MAX_PATTERN * pmf_pkg::BYTE_W;

  // Command being played out, one byte a cycle while text_out.ready is high
  logic               busy;
  logic [BYTES_W-1:0] bytes;
  logic [CNT_W-1:0]   rem;
  logic               star;
  logic               last;
  logic               final_byte;
  logic               load;

  assign final_byte = (rem == CNT_W'(1));
  assign load       = cmd_valid && (!busy || (text_out.ready && final_byte));
  assign cmd_ready  = load;

  assign text_out.valid    = busy;
  assign text_out.out_byte = star ? pmf_pkg::STAR_BYTE : bytes[pmf_pkg::BYTE_W-1:0];
  assign text_out.out_last = last && final_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (load) begin
      busy <= 1'b1;
    end else if (busy && text_out.ready && final_byte) begin
      busy <= 1'b0;
    end
  end

  // Payload: load a new command or step to the next byte
  always_ff @(posedge clk) begin
    if (load) begin
      bytes <= cmd[BYTES_W-1:0];
      rem   <= cmd[BYTES_W +: CNT_W];
      star  <= cmd[CMD_W-2];
      last  <= cmd[CMD_W-1];
    end else if (busy && text_out.ready) begin
      bytes <= bytes >> pmf_pkg::BYTE_W;
      rem   <= rem - CNT_W'(1);
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/pattern_mask_filter_top.sv */
`default_nettype none
// Pattern mask filter: replaces each occurrence of a configured byte pattern
// in a text stream with '*' bytes (leftmost first, no overlap).
// Channels: text_in carries one text word per handshake (in_byte, in_last);
// text_out carries one result word (out_byte, out_last). Both use valid/ready.
// Configuration: cfg_we with cfg_index 0 (pattern_len), 1 (pattern_low) or
// 2 (pattern_high) and cfg_data; write only while the stream is idle. A
// pattern_len write also empties the window.
// Throughput: one input word per cycle while the queue has room. The front
// end classifies each word against the full window in the same cycle and
// pushes a command into a two-entry queue when the word yields output; the
// back end plays commands out at one byte per cycle while text_out.ready is
// high, so a match or an end-of-text flush occupies the output for up to
// MAX_PATTERN bytes while input keeps flowing until the queue fills.
// An accepted word's command is registered in the queue, then in the back end.
// Reset (rst, synchronous): window empty, queue empty, pattern_len = 1,
// pattern words zero. When the receiver stalls, the current output word
// holds, the queue fills, then text_in.ready drops.
module pattern_mask_filter_top #(
  parameter int MAX_PATTERN = pmf_pkg::MAX_PATTERN_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  pmf_in_if.sink                              text_in,
  pmf_out_if.source                           text_out,
  input  wire logic                           cfg_we,
  input  wire logic [pmf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [pmf_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int CNT_W = $clog2(MAX_PATTERN + 1);
  localparam int CMD_W = 2 + CNT_W + MAX_PATTERN * pmf_pkg::BYTE_W;

  logic             fq_valid;
  logic             fq_ready;
  logic [CMD_W-1:0] fq_data;
  logic             qb_valid;
  logic             qb_ready;
  logic [CMD_W-1:0] qb_data;

  pmf_front #(.MAX_PATTERN(MAX_PATTERN)) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .text_in   (text_in),
    .cmd_valid (fq_valid),
    .cmd_ready (fq_ready),
    .cmd       (fq_data)
  );

  pmf_queue #(.WIDTH(CMD_W)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (fq_valid),
    .wr_ready (fq_ready),
    .wr_data  (fq_data),
    .rd_valid (qb_valid),
    .rd_ready (qb_ready),
    .rd_data  (qb_data)
  );

  pmf_back #(.MAX_PATTERN(MAX_PATTERN)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (qb_valid),
    .cmd_ready (qb_ready),
    .cmd       (qb_data),
    .text_out  (text_out)
  );

endmodule
`default_nettype wire
